// ===== src/mrsad_pkg.sv =====
// shared types, field codes and lookup functions for the modrm/sib address decoder
package mrsad_pkg;

    // address size codes
    localparam logic [1:0] MODE_16  = 2'd0;
    localparam logic [1:0] MODE_32  = 2'd1;
    localparam logic [1:0] MODE_64  = 2'd2;
    localparam logic [1:0] MODE_BAD = 2'd3;

    // modrm mod field codes
    localparam logic [1:0] MOD_IND = 2'd0;
    localparam logic [1:0] MOD_D8  = 2'd1;
    localparam logic [1:0] MOD_D32 = 2'd2;
    localparam logic [1:0] MOD_REG = 2'b11;

    // special rm / sib codes
    localparam logic [2:0] RM_SIB       = 3'b100;
    localparam logic [2:0] RM_DISP      = 3'b101;
    localparam logic [2:0] RM_DISP16    = 3'b110;
    localparam logic [2:0] SIB_NO_BASE  = 3'b101;
    localparam logic [3:0] SIB_NO_INDEX = 4'b0100;

    // 16-bit register numbers
    localparam logic [3:0] REG_BX = 4'd3;
    localparam logic [3:0] REG_BP = 4'd5;
    localparam logic [3:0] REG_SI = 4'd6;
    localparam logic [3:0] REG_DI = 4'd7;

    // rip-relative displacement is taken from the end of the disp32 field
    localparam logic [63:0] RIP_DISP_LEN = 64'd4;

    typedef struct packed {
        logic [7:0]  modrm_value;
        logic [7:0]  sib_value;
        logic [31:0] disp_window;
        logic [1:0]  addr_mode;
        logic        rex_base_bit;
        logic        rex_index_bit;
        logic [63:0] after_modrm_addr;
    } item_t;

    typedef struct packed {
        logic        mem_operand;
        logic [2:0]  reg_bits;
        logic        base_present;
        logic [3:0]  base_number;
        logic        index_present;
        logic [3:0]  index_number;
        logic [1:0]  scale_shift;
        logic [63:0] displacement;
        logic [2:0]  extra_bytes;
        logic        rip_relative;
        logic        bad_mode;
    } result_t;

    // 16-bit base register per rm
    function automatic logic [3:0] base16(input logic [2:0] rm);
        logic [3:0] r;
        unique case (rm)
            3'd0, 3'd1, 3'd7: r = REG_BX;
            3'd2, 3'd3, 3'd6: r = REG_BP;
            3'd4:             r = REG_SI;
            default:          r = REG_DI;
        endcase
        return r;
    endfunction

    // 16-bit index register for rm 0..3
    function automatic logic [3:0] index16(input logic [2:0] rm);
        return rm[0] ? REG_DI : REG_SI;
    endfunction

endpackage

// ===== src/mrsad_if.sv =====
// valid/ready channel interfaces for decoder items and results
interface mrsad_item_if;
    import mrsad_pkg::*;

    logic  valid;
    logic  ready;
    item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface mrsad_result_if;
    import mrsad_pkg::*;

    logic    valid;
    logic    ready;
    result_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== src/mrsad_decode.sv =====
// combinational modrm/sib field decode and displacement forming
module mrsad_decode (
    input  mrsad_pkg::item_t   item,
    output mrsad_pkg::result_t result
);
    import mrsad_pkg::*;

    logic [1:0]  mod_f;
    logic [2:0]  rm;
    logic [2:0]  sbase;
    logic [3:0]  sidx;
    logic        wide;
    logic [63:0] sx8;
    logic [63:0] sx32;
    logic [63:0] zx16;
    logic [63:0] sx8_16;
    logic [63:0] mask;
    logic [63:0] rip_addr;

    assign mod_f  = item.modrm_value[7:6];
    assign rm     = item.modrm_value[2:0];
    assign sbase  = item.sib_value[2:0];
    assign sidx   = {item.rex_index_bit, item.sib_value[5:3]};
    assign wide   = (item.addr_mode == MODE_64);
    assign sx8    = {{56{item.disp_window[7]}}, item.disp_window[7:0]};
    assign sx32   = {{32{item.disp_window[31]}}, item.disp_window};
    assign zx16   = {48'd0, item.disp_window[15:0]};
    assign sx8_16 = {48'd0, {8{item.disp_window[7]}}, item.disp_window[7:0]};
    assign mask   = wide ? {64{1'b1}} : {32'd0, {32{1'b1}}};
    assign rip_addr = item.after_modrm_addr + RIP_DISP_LEN + sx32;

    always_comb
    begin
        result = '0;
        if (item.addr_mode == MODE_BAD)
        begin
            result.bad_mode = 1'b1;
        end
        else
        begin
            result.reg_bits = item.modrm_value[5:3];
            if (mod_f == MOD_REG)
            begin
                result.base_number = {(item.addr_mode != MODE_16) & item.rex_base_bit, rm};
            end
            else if (item.addr_mode == MODE_16)
            begin
                result.mem_operand = 1'b1;
                if (mod_f == MOD_IND && rm == RM_DISP16)
                begin
                    result.displacement = zx16;
                    result.extra_bytes  = 3'd2;
                end
                else
                begin
                    result.base_present = 1'b1;
                    result.base_number  = base16(rm);
                    if (!rm[2])
                    begin
                        result.index_present = 1'b1;
                        result.index_number  = index16(rm);
                    end
                    if (mod_f == MOD_D8)
                    begin
                        result.displacement = sx8_16;
                        result.extra_bytes  = 3'd1;
                    end
                    else if (mod_f == MOD_D32)
                    begin
                        result.displacement = zx16;
                        result.extra_bytes  = 3'd2;
                    end
                end
            end
            else
            begin
                result.mem_operand = 1'b1;
                if (mod_f == MOD_IND && rm == RM_DISP)
                begin
                    result.extra_bytes = 3'd4;
                    if (wide)
                    begin
                        result.displacement = rip_addr;
                        result.rip_relative = 1'b1;
                    end
                    else
                    begin
                        result.displacement = {32'd0, item.disp_window};
                    end
                end
                else
                begin
                    if (rm == RM_SIB)
                    begin
                        result.extra_bytes = 3'd1;
                        if (sbase == SIB_NO_BASE && mod_f == MOD_IND)
                        begin
                            // no base register, disp32 in its place; an index may still apply
                            result.displacement = sx32 & mask;
                            result.extra_bytes  = 3'd5;
                        end
                        else
                        begin
                            result.base_present = 1'b1;
                            result.base_number  = {item.rex_base_bit, sbase};
                        end
                        if (sidx != SIB_NO_INDEX)
                        begin
                            result.index_present = 1'b1;
                            result.index_number  = sidx;
                            result.scale_shift   = item.sib_value[7:6];
                        end
                    end
                    else
                    begin
                        result.base_present = 1'b1;
                        result.base_number  = {item.rex_base_bit, rm};
                    end
                    if (mod_f == MOD_D8)
                    begin
                        result.displacement = sx8 & mask;
                        result.extra_bytes  = result.extra_bytes + 3'd1;
                    end
                    else if (mod_f == MOD_D32)
                    begin
                        result.displacement = sx32 & mask;
                        result.extra_bytes  = result.extra_bytes + 3'd4;
                    end
                end
            end
        end
    end

endmodule

// ===== src/x86_modrm_sib_address_decoder_unit.sv =====
// top level: input register, operand decode, result register
// path: an item is held in the input register, decoded, then held in the result register, where it is offered
// throughput: one item per cycle while result.ready holds, set by the single decode pass
// between the two registers
// a stalled result holds in the result register while one more item waits in the input register
// reset clears both valid flags; payload registers are not reset
module x86_modrm_sib_address_decoder_unit (
    input  logic                  clk,
    input  logic                  rst_n,
    mrsad_item_if.sink            item,
    mrsad_result_if.source        result
);
    import mrsad_pkg::*;

    item_t   item_reg;
    logic    item_valid_reg;
    logic    item_valid_next;
    result_t result_reg;
    logic    result_valid_reg;
    logic    result_valid_next;
    result_t decoded;
    logic    result_load;
    logic    item_load;

    // result slot frees when empty or when its transfer completes this cycle
    assign result_load = item_valid_reg && (!result_valid_reg || result.ready);
    // input slot takes a new item when empty or moving on to the result slot
    assign item.ready  = !item_valid_reg || result_load;
    assign item_load   = item.valid && item.ready;

    assign result.valid = result_valid_reg;
    assign result.data  = result_reg;

    // all field decode and the rip-relative add
    mrsad_decode u_decode (
        .item   (item_reg),
        .result (decoded)
    );

    always_comb
    begin
        item_valid_next = item_valid_reg;
        if (item.ready)
        begin
            item_valid_next = item.valid;
        end
        result_valid_next = result_valid_reg;
        if (result_load)
        begin
            result_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            result_valid_next = 1'b0;
        end
    end

    // control flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            item_valid_reg   <= item_valid_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (item_load)
        begin
            item_reg <= item.data;
        end
        if (result_load)
        begin
            result_reg <= decoded;
        end
    end

endmodule
